// ===== rtl/pfa_pkg.sv =====
// pfa_pkg: shared types and constants for the paged frame allocator
// holds field widths, register indexes, input modes, result status codes and fsm states
// no dependencies
package pfa_pkg;

    // default frame table depth
    localparam int MAX_FRAMES_DEF = 64;

    // field widths
    localparam int SIZE_W = 16;
    localparam int TAG_W  = 16;
    localparam int DIV_W  = SIZE_W + 1;
    localparam int CFG_AW = 2;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_MEMORY_SIZE = 2'd0;
    localparam logic [CFG_AW-1:0] REG_SYSTEM_SIZE = 2'd1;
    localparam logic [CFG_AW-1:0] REG_PAGE_SIZE   = 2'd2;

    // input modes
    localparam logic MODE_FORMAT   = 1'b0;
    localparam logic MODE_ALLOCATE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        STAT_MAPPED  = 2'd0,
        STAT_DONE    = 2'd1,
        STAT_NO_FREE = 2'd2,
        STAT_CFG_ERR = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_MEM,
        S_DIV_SYS,
        S_DIV_PROC,
        S_CLEAR,
        S_SCAN
    } t_state;

endpackage

// ===== rtl/pfa_div.sv =====
// pfa_div: iterative restoring divider, one quotient bit per cycle
// unsigned numerator of NUM_W bits over a nonzero divisor of DEN_W bits
// depends on pfa_pkg for default widths
module pfa_div #(
    parameter int NUM_W = pfa_pkg::DIV_W,
    parameter int DEN_W = pfa_pkg::SIZE_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_den, n_den;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    // one shift and trial subtract per cycle
    always_comb begin
        shifted = {r_rem, r_quo[NUM_W-1]};
        diff    = shifted - {1'b0, r_den};
        ge      = (shifted >= {1'b0, r_den});
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_den   = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(NUM_W);
            n_rem  = '0;
            n_quo  = i_num;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            n_quo = {r_quo[NUM_W-2:0], ge};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/pfa_ftab.sv =====
// pfa_ftab: frame table, one used bit per frame
// synchronous single write port and single read port, read data registered
// depends on pfa_pkg for the default depth
module pfa_ftab #(
    parameter int MAX_FRAMES = pfa_pkg::MAX_FRAMES_DEF,
    parameter int FW         = $clog2(MAX_FRAMES)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [FW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic [FW-1:0] i_raddr,
    output logic          o_rdata
);

    logic       mem [MAX_FRAMES];
    logic       r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/paged_frame_allocator_unit.sv =====
// paged_frame_allocator_unit: top level of the paged frame allocator
// instantiates pfa_div and pfa_ftab, uses pfa_pkg
//
// Usage
//   config: write memory, system and page sizes (index 0, 1, 2) on i_cfg_*
//   while the block is idle; o_cfg_ready is always high.
//   items: drive i_mode, i_process_id, i_process_size_kb with i_start; the
//   item is taken when i_start is high and o_busy is low.
//   results: each result is shown for one cycle with o_valid; o_last marks
//   the final result of an item. The receiver cannot stall.
// Timing
//   a rejected item (a zero configuration size) answers in the cycle after it is taken.
//   format: two divisions in the shared divider, then, unless the system
//   frames exceed the memory frames, a sweep that writes every frame table
//   entry (MAX_FRAMES of them), one per cycle.
//   allocate: one division, then, unless the item needs no pages or more
//   than are free, a scan of the frame table from the first non-system frame,
//   one entry per cycle with registered read data; one mapping result for
//   each free frame read. Items are processed one at a time; o_busy is high
//   until the last result has been issued.
// Reset
//   synchronous, active low: control state, counts and the result valid clear.
//   The frame table holds no reset value and is never read before a format writes it.
module paged_frame_allocator_unit #(
    parameter int MAX_FRAMES = pfa_pkg::MAX_FRAMES_DEF,
    parameter int FW         = $clog2(MAX_FRAMES),
    parameter int CW         = $clog2(MAX_FRAMES + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [pfa_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [pfa_pkg::SIZE_W-1:0] i_cfg_wdata,
    // item channel
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic                       i_mode,
    input  logic [pfa_pkg::TAG_W-1:0]  i_process_id,
    input  logic [pfa_pkg::SIZE_W-1:0] i_process_size_kb,
    // result channel
    output logic                       o_valid,
    output logic [pfa_pkg::TAG_W-1:0]  o_process_tag,
    output logic [FW-1:0]              o_page_index,
    output logic [FW-1:0]              o_frame_number,
    output logic [1:0]                 o_status,
    output logic [CW-1:0]              o_free_frames,
    output logic                       o_last
);

    localparam int SW = pfa_pkg::SIZE_W;
    localparam int DW = pfa_pkg::DIV_W;
    localparam int TW = pfa_pkg::TAG_W;

    // configuration registers
    logic [SW-1:0] r_mem_kb, r_sys_kb, r_page_kb;

    // allocator state
    pfa_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_total, n_total;
    logic [CW-1:0] r_sysf, n_sysf;
    logic [CW-1:0] r_free, n_free;

    // per-item working registers
    logic [CW-1:0] r_nf, n_nf;
    logic [CW-1:0] r_ns, n_ns;
    logic [CW-1:0] r_pages, n_pages;
    logic [CW-1:0] r_done, n_done;
    logic [CW-1:0] r_addr, n_addr;
    logic          r_rd_vld, n_rd_vld;
    logic [FW-1:0] r_rd_idx, n_rd_idx;
    logic [TW-1:0] r_tag, n_tag;

    // result registers
    logic             r_out_vld, n_out_vld;
    logic [TW-1:0]    r_out_tag, n_out_tag;
    logic [FW-1:0]    r_out_page, n_out_page;
    logic [FW-1:0]    r_out_frame, n_out_frame;
    pfa_pkg::t_status r_out_status, n_out_status;
    logic [CW-1:0]    r_out_free, n_out_free;
    logic             r_out_last, n_out_last;

    // divider and frame table hookup
    logic          div_start;
    logic [DW-1:0] div_num;
    logic          div_done;
    logic [DW-1:0] div_quo;
    logic          ft_we;
    logic [FW-1:0] ft_waddr;
    logic          ft_wdata;
    logic          ft_rdata;

    // decode
    logic          accept;
    logic          accept_err;
    logic [DW-1:0] sys_round;
    logic [DW-1:0] proc_round;
    logic [CW-1:0] nf_cap;
    logic          issue;
    logic          hit;
    logic          hit_last;
    logic          scan_dry;
    logic          clear_end;

    pfa_div #(
        .NUM_W (DW),
        .DEN_W (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_page_kb),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    pfa_ftab #(
        .MAX_FRAMES (MAX_FRAMES),
        .FW         (FW)
    ) u_ftab (
        .i_clk   (i_clk),
        .i_we    (ft_we),
        .i_waddr (ft_waddr),
        .i_wdata (ft_wdata),
        .i_raddr (r_addr[FW-1:0]),
        .o_rdata (ft_rdata)
    );

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_kb  <= '0;
            r_sys_kb  <= '0;
            r_page_kb <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                pfa_pkg::REG_MEMORY_SIZE: r_mem_kb  <= i_cfg_wdata;
                pfa_pkg::REG_SYSTEM_SIZE: r_sys_kb  <= i_cfg_wdata;
                pfa_pkg::REG_PAGE_SIZE:   r_page_kb <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // shared decode terms
    always_comb begin
        accept     = i_start && (r_state == pfa_pkg::S_IDLE);
        accept_err = (i_mode == pfa_pkg::MODE_FORMAT) ?
                     ((r_mem_kb == '0) || (r_sys_kb == '0) || (r_page_kb == '0)) :
                     (r_page_kb == '0);
        sys_round  = {1'b0, r_sys_kb} + {1'b0, r_page_kb} - DW'(1);
        proc_round = {1'b0, i_process_size_kb} + {1'b0, r_page_kb} - DW'(1);
        nf_cap     = (div_quo > DW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : div_quo[CW-1:0];
        issue      = (r_addr < r_total);
        hit        = r_rd_vld && !ft_rdata;
        hit_last   = hit && ((r_done + CW'(1)) == r_pages);
        scan_dry   = !issue && !r_rd_vld;
        clear_end  = (r_addr == CW'(MAX_FRAMES - 1));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfa_pkg::S_IDLE: begin
                if (accept && !accept_err) begin
                    n_state = (i_mode == pfa_pkg::MODE_FORMAT) ?
                              pfa_pkg::S_DIV_MEM : pfa_pkg::S_DIV_PROC;
                end
            end
            pfa_pkg::S_DIV_MEM: begin
                if (div_done) n_state = pfa_pkg::S_DIV_SYS;
            end
            pfa_pkg::S_DIV_SYS: begin
                if (div_done) begin
                    n_state = (div_quo > DW'(r_nf)) ? pfa_pkg::S_IDLE : pfa_pkg::S_CLEAR;
                end
            end
            pfa_pkg::S_DIV_PROC: begin
                if (div_done) begin
                    n_state = ((div_quo > DW'(r_free)) || (div_quo == '0)) ?
                              pfa_pkg::S_IDLE : pfa_pkg::S_SCAN;
                end
            end
            pfa_pkg::S_CLEAR: begin
                if (clear_end) n_state = pfa_pkg::S_IDLE;
            end
            pfa_pkg::S_SCAN: begin
                if (hit_last || scan_dry) n_state = pfa_pkg::S_IDLE;
            end
            default: n_state = pfa_pkg::S_IDLE;
        endcase
    end

    // datapath, memory accesses and results
    always_comb begin
        n_total      = r_total;
        n_sysf       = r_sysf;
        n_free       = r_free;
        n_nf         = r_nf;
        n_ns         = r_ns;
        n_pages      = r_pages;
        n_done       = r_done;
        n_addr       = r_addr;
        n_rd_vld     = 1'b0;
        n_rd_idx     = r_rd_idx;
        n_tag        = r_tag;
        n_out_vld    = 1'b0;
        n_out_tag    = r_out_tag;
        n_out_page   = '0;
        n_out_frame  = '0;
        n_out_status = r_out_status;
        n_out_free   = r_free;
        n_out_last   = 1'b1;
        div_start    = 1'b0;
        div_num      = {1'b0, r_mem_kb};
        ft_we        = 1'b0;
        ft_waddr     = r_rd_idx;
        ft_wdata     = 1'b1;
        case (r_state)
            pfa_pkg::S_IDLE: begin
                if (accept) begin
                    n_tag = i_process_id;
                    if (accept_err) begin
                        n_out_vld    = 1'b1;
                        n_out_tag    = i_process_id;
                        n_out_status = pfa_pkg::STAT_CFG_ERR;
                    end else begin
                        div_start = 1'b1;
                        div_num   = (i_mode == pfa_pkg::MODE_FORMAT) ?
                                    {1'b0, r_mem_kb} : proc_round;
                    end
                end
            end
            pfa_pkg::S_DIV_MEM: begin
                if (div_done) begin
                    n_nf      = nf_cap;
                    div_start = 1'b1;
                    div_num   = sys_round;
                end
            end
            pfa_pkg::S_DIV_SYS: begin
                if (div_done) begin
                    n_ns   = div_quo[CW-1:0];
                    n_addr = '0;
                    if (div_quo > DW'(r_nf)) begin
                        n_out_vld    = 1'b1;
                        n_out_tag    = r_tag;
                        n_out_status = pfa_pkg::STAT_CFG_ERR;
                    end
                end
            end
            pfa_pkg::S_DIV_PROC: begin
                if (div_done) begin
                    n_pages = div_quo[CW-1:0];
                    n_done  = '0;
                    n_addr  = r_sysf;
                    if (div_quo > DW'(r_free)) begin
                        n_out_vld    = 1'b1;
                        n_out_tag    = r_tag;
                        n_out_status = pfa_pkg::STAT_NO_FREE;
                    end else if (div_quo == '0) begin
                        n_out_vld    = 1'b1;
                        n_out_tag    = r_tag;
                        n_out_status = pfa_pkg::STAT_DONE;
                    end
                end
            end
            pfa_pkg::S_CLEAR: begin
                // system frames used, all others free
                ft_we    = 1'b1;
                ft_waddr = r_addr[FW-1:0];
                ft_wdata = (r_addr < r_ns);
                n_addr   = r_addr + CW'(1);
                if (clear_end) begin
                    n_total      = r_nf;
                    n_sysf       = r_ns;
                    n_free       = r_nf - r_ns;
                    n_out_vld    = 1'b1;
                    n_out_tag    = r_tag;
                    n_out_status = pfa_pkg::STAT_DONE;
                    n_out_free   = r_nf - r_ns;
                end
            end
            pfa_pkg::S_SCAN: begin
                // read one entry per cycle, decide on the entry read last cycle
                n_addr   = issue ? (r_addr + CW'(1)) : r_addr;
                n_rd_vld = issue && !hit_last;
                n_rd_idx = r_addr[FW-1:0];
                if (hit) begin
                    ft_we        = 1'b1;
                    n_free       = r_free - CW'(1);
                    n_done       = r_done + CW'(1);
                    n_out_vld    = 1'b1;
                    n_out_tag    = r_tag;
                    n_out_page   = r_done[FW-1:0];
                    n_out_frame  = r_rd_idx;
                    n_out_status = pfa_pkg::STAT_MAPPED;
                    n_out_free   = r_free - CW'(1);
                    n_out_last   = hit_last;
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pfa_pkg::S_IDLE;
            r_total   <= '0;
            r_sysf    <= '0;
            r_free    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_total   <= n_total;
            r_sysf    <= n_sysf;
            r_free    <= n_free;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_nf         <= n_nf;
        r_ns         <= n_ns;
        r_pages      <= n_pages;
        r_done       <= n_done;
        r_addr       <= n_addr;
        r_rd_idx     <= n_rd_idx;
        r_tag        <= n_tag;
        r_out_tag    <= n_out_tag;
        r_out_page   <= n_out_page;
        r_out_frame  <= n_out_frame;
        r_out_status <= n_out_status;
        r_out_free   <= n_out_free;
        r_out_last   <= n_out_last;
    end

    // outputs
    assign o_busy         = (r_state != pfa_pkg::S_IDLE);
    assign o_valid        = r_out_vld;
    assign o_process_tag  = r_out_tag;
    assign o_page_index   = r_out_page;
    assign o_frame_number = r_out_frame;
    assign o_status       = r_out_status;
    assign o_free_frames  = r_out_free;
    assign o_last         = r_out_last;

    // free count never exceeds the formatted frame count
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= r_total)
        else $error("free count above total frames");

    // leaving a busy item always issues its final result
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_busy) && $past(i_rst_n)) |-> (o_valid && o_last))
        else $error("item finished without a final result");

    // mapped frames lie above the system area and inside the table
    a_frame_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == pfa_pkg::STAT_MAPPED)) |->
        ((CW'(o_frame_number) >= r_sysf) && (CW'(o_frame_number) < r_total)))
        else $error("mapped frame outside the allocatable range");

endmodule
